/* hw/rtl/mtfd_pkg.sv */
// ----------------------------------------------------------------------------
// mtfd_pkg
// Shared codes and types of the move-to-front dictionary.
// ----------------------------------------------------------------------------
package mtfd_pkg;

  // operation codes of the func field
  localparam logic [2:0] FN_INSERT   = 3'd0;
  localparam logic [2:0] FN_ATTACH   = 3'd1;
  localparam logic [2:0] FN_FIND_POS = 3'd2;
  localparam logic [2:0] FN_READ_AT  = 3'd3;
  localparam logic [2:0] FN_FIND_PAY = 3'd4;

  // cells examined per search step
  localparam int GRP_CELLS = 8;

  // controls broadcast from the sequencer to every cell
  typedef struct packed {
    logic cmp_en;    // capture key match
    logic sel_en;    // capture rank select
    logic shift_en;  // take neighbor entry when at or below the shift limit
    logic write_en;  // overwrite payload of the selected cell
  } cell_ctl_t;

endpackage

/* hw/rtl/move_to_front_dictionary.sv */
// ----------------------------------------------------------------------------
// move_to_front_dictionary
// Move-to-front word dictionary built from a row of key/payload cells.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_func, in_key, in_payload and in_position and pulse start while
//   busy is low; the request is taken at that edge. busy stays high until the
//   result strobe, so one request is in work at a time.
//   Each request gives exactly one result: out_valid is high for one cycle
//   with out_hit, out_rank, out_key_out, out_payload_out and out_overflow.
//   The receiver cannot stall; results are never held.
// Sequence, from the accepting edge to the strobe cycle:
//   key compare in every cell (ST_CMP), then a search of the match bits one
//   group of 8 cells per cycle (ST_SCAN, ending at the first group with a
//   match or at the last group), then ST_SEL and ST_DAT to pick the found
//   cell's data on a hit (attach, find payload, read at position), then ST_ACT
//   to update the cells. Read at position and the unused codes skip the
//   search. A new request can be taken in the strobe cycle.
// Reset: the entry count clears and the table reads as empty; stored keys and
//   payloads are not cleared, entries past the count are never matched.
// ----------------------------------------------------------------------------
module move_to_front_dictionary
  import mtfd_pkg::*;
#(
  parameter int TABLE_DEPTH  = 64,
  parameter int KEY_BITS     = 64,
  parameter int PAYLOAD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_func,
  input  logic [63:0] in_key,
  input  logic [15:0] in_payload,
  input  logic [5:0]  in_position,
  output logic        out_valid,
  output logic        out_hit,
  output logic [5:0]  out_rank,
  output logic [63:0] out_key_out,
  output logic [15:0] out_payload_out,
  output logic        out_overflow
);

  // stored payload is the port width cut to PAYLOAD_BITS
  localparam int PW   = (PAYLOAD_BITS < 16) ? PAYLOAD_BITS : 16;
  localparam int KW   = KEY_BITS;
  localparam int RW   = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
  localparam int FW   = $clog2(TABLE_DEPTH + 1);
  localparam int NGRP = (TABLE_DEPTH + GRP_CELLS - 1) / GRP_CELLS;
  localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int SW   = $clog2(GRP_CELLS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_SCAN,
    ST_SEL,
    ST_DAT,
    ST_ACT
  } state_t;

  state_t        state_r;
  logic [2:0]    func_r;
  logic [KW-1:0] key_r;
  logic [PW-1:0] pay_r;
  logic [5:0]    pos_r;
  logic [FW-1:0] fill_r;
  logic [GW-1:0] grp_r;
  logic [RW-1:0] rank_r;
  logic          hit_r;
  logic [KW-1:0] fkey_r;
  logic [PW-1:0] fpay_r;

  logic          out_valid_r;
  logic          out_hit_r;
  logic [5:0]    out_rank_r;
  logic [63:0]   out_key_r;
  logic [15:0]   out_pay_r;
  logic          out_ovf_r;

  cell_ctl_t     ctl;
  logic [RW-1:0] shift_lim;
  logic          table_full;

  logic [KW-1:0] cell_key   [TABLE_DEPTH];
  logic [PW-1:0] cell_pay   [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] cell_match;
  logic [TABLE_DEPTH-1:0] cell_sel;
  logic [NGRP*GRP_CELLS-1:0] match_pad;

  logic [GRP_CELLS-1:0] grp_bits;
  logic                 grp_any;
  logic [SW-1:0]        grp_first;
  logic                 grp_last;
  logic [KW-1:0]        sel_key;
  logic [PW-1:0]        sel_pay;
  logic                 needs_data;
  logic                 read_ok;

  // ---- cell row -----------------------------------------------------------
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [KW-1:0] prev_key;
    logic [PW-1:0] prev_pay;
    if (i == 0) begin : g_head
      // front cell takes the new entry on a shift
      assign prev_key = key_r;
      assign prev_pay = pay_r;
    end else begin : g_body
      assign prev_key = cell_key[i-1];
      assign prev_pay = cell_pay[i-1];
    end
    mtfd_cell #(
      .IDX (i),
      .KW  (KW),
      .PW  (PW),
      .RW  (RW),
      .FW  (FW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .bcast_key  (key_r),
      .bcast_pay  (pay_r),
      .bcast_rank (rank_r),
      .shift_lim  (shift_lim),
      .fill       (fill_r),
      .prev_key   (prev_key),
      .prev_pay   (prev_pay),
      .key_q      (cell_key[i]),
      .pay_q      (cell_pay[i]),
      .match_q    (cell_match[i]),
      .sel_q      (cell_sel[i])
    );
  end

  // pad the match bits to whole groups
  always_comb begin
    match_pad = '0;
    match_pad[TABLE_DEPTH-1:0] = cell_match;
  end

  // ---- group search -------------------------------------------------------
  assign grp_bits = match_pad[{grp_r, {SW{1'b0}}} +: GRP_CELLS];
  assign grp_any  = |grp_bits;
  assign grp_last = (grp_r == GW'(NGRP - 1));

  // lowest set bit of the group is the match nearest the front
  always_comb begin
    grp_first = '0;
    for (int j = GRP_CELLS - 1; j >= 0; j--) begin
      if (grp_bits[j]) begin
        grp_first = SW'(j);
      end
    end
  end

  // ---- data of the selected cell ------------------------------------------
  always_comb begin
    sel_key = '0;
    sel_pay = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      sel_key = sel_key | (cell_key[i] & {KW{cell_sel[i]}});
      sel_pay = sel_pay | (cell_pay[i] & {PW{cell_sel[i]}});
    end
  end

  // ---- cell controls ------------------------------------------------------
  assign table_full = (fill_r == FW'(TABLE_DEPTH));

  always_comb begin
    if (hit_r) begin
      shift_lim = rank_r;
    end else if (table_full) begin
      shift_lim = RW'(TABLE_DEPTH - 1);
    end else begin
      shift_lim = RW'(fill_r);
    end
  end

  always_comb begin
    ctl          = '0;
    ctl.cmp_en   = (state_r == ST_CMP);
    ctl.sel_en   = (state_r == ST_SEL);
    ctl.shift_en = (state_r == ST_ACT) && (func_r == FN_INSERT);
    ctl.write_en = (state_r == ST_ACT) && (func_r == FN_ATTACH) && hit_r
                   && (fpay_r == '0);
  end

  assign needs_data = (func_r == FN_ATTACH) || (func_r == FN_FIND_PAY);
  assign read_ok    = (32'(pos_r) < 32'(fill_r));

  // ---- sequencer ----------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            // hold the request for the whole operation
            func_r  <= in_func;
            key_r   <= in_key[KW-1:0];
            pay_r   <= in_payload[PW-1:0];
            pos_r   <= in_position;
            grp_r   <= '0;
            state_r <= ST_CMP;
          end
        end
        ST_CMP: begin
          // cells capture their match bits at this edge
          hit_r  <= 1'b0;
          rank_r <= '0;
          grp_r  <= '0;
          if (func_r == FN_READ_AT) begin
            hit_r   <= read_ok;
            rank_r  <= read_ok ? RW'(pos_r) : '0;
            state_r <= read_ok ? ST_SEL : ST_ACT;
          end else if (func_r == FN_INSERT || func_r == FN_ATTACH ||
                       func_r == FN_FIND_POS || func_r == FN_FIND_PAY) begin
            state_r <= ST_SCAN;
          end else begin
            state_r <= ST_ACT;
          end
        end
        ST_SCAN: begin
          // advance one group a cycle until the first match or the last group
          if (grp_any) begin
            hit_r   <= 1'b1;
            rank_r  <= RW'({grp_r, grp_first});
            state_r <= needs_data ? ST_SEL : ST_ACT;
          end else if (grp_last) begin
            hit_r   <= 1'b0;
            rank_r  <= '0;
            state_r <= ST_ACT;
          end else begin
            grp_r <= grp_r + 1'b1;
          end
        end
        ST_SEL: begin
          // cells capture their select bits at this edge
          state_r <= ST_DAT;
        end
        ST_DAT: begin
          fkey_r  <= sel_key;
          fpay_r  <= sel_pay;
          state_r <= ST_ACT;
        end
        ST_ACT: begin
          out_valid_r <= 1'b1;
          out_hit_r   <= hit_r;
          out_rank_r  <= hit_r ? 6'(rank_r) : 6'd0;
          out_key_r   <= '0;
          out_pay_r   <= '0;
          out_ovf_r   <= 1'b0;
          unique case (func_r)
            FN_INSERT: begin
              if (!hit_r) begin
                if (table_full) begin
                  out_ovf_r <= 1'b1;
                end else begin
                  fill_r <= fill_r + 1'b1;
                end
              end
            end
            FN_ATTACH: begin
              if (hit_r) begin
                out_pay_r <= 16'((fpay_r == '0) ? pay_r : fpay_r);
              end
            end
            FN_READ_AT: begin
              if (hit_r) begin
                out_key_r <= 64'(fkey_r);
                out_pay_r <= 16'(fpay_r);
              end
            end
            FN_FIND_PAY: begin
              if (hit_r) begin
                out_pay_r <= 16'(fpay_r);
              end
            end
            default: begin
            end
          endcase
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_rank        = out_rank_r;
  assign out_key_out     = out_key_r;
  assign out_payload_out = out_pay_r;
  assign out_overflow    = out_ovf_r;

endmodule

/* hw/rtl/mtfd_cell.sv */
// ----------------------------------------------------------------------------
// mtfd_cell
// One dictionary slot: holds a key and payload, matches the broadcast key and
// takes its front neighbor's entry on a shift.
// ----------------------------------------------------------------------------
module mtfd_cell
  import mtfd_pkg::*;
#(
  parameter int IDX = 0,
  parameter int KW  = 64,
  parameter int PW  = 16,
  parameter int RW  = 6,
  parameter int FW  = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cell_ctl_t     ctl,
  input  logic [KW-1:0] bcast_key,
  input  logic [PW-1:0] bcast_pay,
  input  logic [RW-1:0] bcast_rank,
  input  logic [RW-1:0] shift_lim,
  input  logic [FW-1:0] fill,
  input  logic [KW-1:0] prev_key,
  input  logic [PW-1:0] prev_pay,
  output logic [KW-1:0] key_q,
  output logic [PW-1:0] pay_q,
  output logic          match_q,
  output logic          sel_q
);

  logic [KW-1:0] key_r;
  logic [PW-1:0] pay_r;
  logic          match_r;
  logic          sel_r;
  logic          in_shift;

  assign in_shift = ctl.shift_en && (RW'(IDX) <= shift_lim);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      if (ctl.cmp_en) begin
        match_r <= (FW'(IDX) < fill) && (key_r == bcast_key);
      end
      if (ctl.sel_en) begin
        sel_r <= (RW'(IDX) == bcast_rank);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_shift) begin
      key_r <= prev_key;
      pay_r <= prev_pay;
    end else if (ctl.write_en && sel_r) begin
      pay_r <= bcast_pay;
    end
  end

  assign key_q   = key_r;
  assign pay_q   = pay_r;
  assign match_q = match_r;
  assign sel_q   = sel_r;

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench of the move-to-front word dictionary.
// A short table of directed requests covers the empty table, the field
// extremes, every operation and the unused codes. About 850 random requests
// follow, with keys drawn mostly from a pool a little larger than the table,
// so that hits, moves to the front, payload attaches and overflows are all
// frequent. Every result is checked against an in-order queue filled by a
// behavioral copy of the dictionary or by the typed answer of a directed row.
// ----------------------------------------------------------------------------
module tb;
  import mtfd_pkg::*;

  localparam int DEPTH       = 64;
  localparam int POOL_SIZE   = 96;
  localparam int RAND_ITEMS  = 850;
  localparam int MAX_GAP     = 12;
  localparam int SETTLE_CYC  = 16;
  localparam int REPORT_MAX  = 10;

  // func codes that the block ignores
  localparam logic [2:0] FN_RSVD5 = 3'd5;
  localparam logic [2:0] FN_RSVD6 = 3'd6;
  localparam logic [2:0] FN_RSVD7 = 3'd7;

  localparam logic [63:0] KEY_ONES = {64{1'b1}};

  typedef struct packed {
    logic        hit;
    logic [5:0]  rank;
    logic [63:0] key_out;
    logic [15:0] payload_out;
    logic        overflow;
  } dict_result_t;

  // one request of the directed table; typed rows carry their own answer
  typedef struct {
    logic [2:0]   fn;
    logic [63:0]  key;
    logic [15:0]  pay;
    logic [5:0]   pos;
    bit           typed;
    dict_result_t want;
  } request_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_func = '0;
  logic [63:0] in_key = '0;
  logic [15:0] in_payload = '0;
  logic [5:0]  in_position = '0;
  logic        out_valid;
  logic        out_hit;
  logic [5:0]  out_rank;
  logic [63:0] out_key_out;
  logic [15:0] out_payload_out;
  logic        out_overflow;

  // behavioral copy of the dictionary contents
  logic [63:0] dict_keys [DEPTH];
  logic [15:0] dict_pays [DEPTH];
  int          dict_fill = 0;

  dict_result_t pending_results [$];
  request_t     directed [$];
  logic [63:0]  key_pool [POOL_SIZE];
  int           mismatches = 0;

  move_to_front_dictionary dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_key          (in_key),
    .in_payload      (in_payload),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_rank        (out_rank),
    .out_key_out     (out_key_out),
    .out_payload_out (out_payload_out),
    .out_overflow    (out_overflow)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Dictionary predictor
  // ---------------------------------------------------------------------------

  // Return the rank of the entry nearest the front holding k, or -1.
  function automatic int find_rank(logic [63:0] k);
    for (int i = 0; i < dict_fill; i++) begin
      if (dict_keys[i] == k) return i;
    end
    return -1;
  endfunction

  // Move entries [0, last) back by one place, freeing the front slot.
  function automatic void open_front(int last);
    for (int i = last; i > 0; i--) begin
      dict_keys[i] = dict_keys[i-1];
      dict_pays[i] = dict_pays[i-1];
    end
  endfunction

  // Apply one request to the copy and return the result it must produce.
  function automatic dict_result_t mtf_apply(logic [2:0] fn, logic [63:0] k,
                                             logic [15:0] p, logic [5:0] pos);
    dict_result_t r;
    int           at;
    r  = '0;
    at = find_rank(k);
    case (fn)
      FN_INSERT: begin
        if (at >= 0) begin
          // present: pull it out, the entries in front of it slide back
          r.hit  = 1'b1;
          r.rank = 6'(at);
          open_front(at);
        end else if (dict_fill == DEPTH) begin
          // full: the last entry falls off the back
          r.overflow = 1'b1;
          open_front(DEPTH - 1);
        end else begin
          open_front(dict_fill);
          dict_fill++;
        end
        dict_keys[0] = k;
        dict_pays[0] = p;
      end
      FN_ATTACH: begin
        if (at >= 0) begin
          r.hit  = 1'b1;
          r.rank = 6'(at);
          if (dict_pays[at] == '0) dict_pays[at] = p;
          r.payload_out = dict_pays[at];
        end
      end
      FN_FIND_POS: begin
        if (at >= 0) begin
          r.hit  = 1'b1;
          r.rank = 6'(at);
        end
      end
      FN_READ_AT: begin
        if (int'(pos) < dict_fill) begin
          r.hit         = 1'b1;
          r.rank        = pos;
          r.key_out     = dict_keys[pos];
          r.payload_out = dict_pays[pos];
        end
      end
      FN_FIND_PAY: begin
        if (at >= 0) begin
          r.hit         = 1'b1;
          r.rank        = 6'(at);
          r.payload_out = dict_pays[at];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  function automatic request_t row(logic [2:0] fn, logic [63:0] k, logic [15:0] p,
                                   logic [5:0] pos, bit typed = 1'b0,
                                   dict_result_t want = '0);
    request_t s;
    s.fn    = fn;
    s.key   = k;
    s.pay   = p;
    s.pos   = pos;
    s.typed = typed;
    s.want  = want;
    return s;
  endfunction

  // Drive one request and hold it until the edge that takes it; start stays
  // high afterward so that a back-to-back request keeps it up.
  task automatic issue(request_t s);
    dict_result_t want;
    in_func     <= s.fn;
    in_key      <= s.key;
    in_payload  <= s.pay;
    in_position <= s.pos;
    start       <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    want = mtf_apply(s.fn, s.key, s.pay, s.pos);
    if (s.typed) want = s.want;
    pending_results.push_back(want);
  endtask

  // Drop start and idle for the gap n; with zero start stays up and the request stream stays tight.
  task automatic hold_off(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drop start and wait until every outstanding result is back.
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Random request: mostly pool keys so the table churns, plus some noise
  // with fresh keys and random codes, the unused ones among them.
  function automatic request_t random_request();
    request_t    s;
    int unsigned pick;
    s       = row(FN_INSERT, '0, '0, '0);
    s.pos   = 6'($urandom_range(0, 63));
    s.pay   = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      s.fn  = 3'($urandom_range(0, 7));
      s.key = {$urandom, $urandom};
    end else begin
      s.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      pick  = $urandom_range(0, 99);
      if (pick < 35)      s.fn = FN_INSERT;
      else if (pick < 50) s.fn = FN_ATTACH;
      else if (pick < 65) s.fn = FN_FIND_POS;
      else if (pick < 80) s.fn = FN_READ_AT;
      else                s.fn = FN_FIND_PAY;
    end
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: the receiver cannot stall, so take every strobe
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    dict_result_t got;
    dict_result_t want;
    got = '{hit: out_hit, rank: out_rank, key_out: out_key_out,
            payload_out: out_payload_out, overflow: out_overflow};
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: hit=%0b rank=%0d key=%h pay=%h ovf=%0b",
                   got.hit, got.rank, got.key_out, got.payload_out, got.overflow);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("mismatch at %0t:", $realtime);
            $display("  expected hit=%0b rank=%0d key=%h pay=%h ovf=%0b",
                     want.hit, want.rank, want.key_out, want.payload_out, want.overflow);
            $display("  actual   hit=%0b rank=%0d key=%h pay=%h ovf=%0b",
                     got.hit, got.rank, got.key_out, got.payload_out, got.overflow);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    dict_result_t none;
    bit           no_gaps;
    int           taken;
    request_t     s;

    none = '0;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = KEY_ONES;
    key_pool[1] = '0;

    // Empty table, unused codes, the first inserts and later misses have obvious answers;
    // the rest of the table is left to the predictor.
    directed.push_back(row(FN_FIND_POS, '0, '0, '0, 1'b1, none));
    directed.push_back(row(FN_READ_AT, '0, '0, 6'd0, 1'b1, none));
    directed.push_back(row(FN_FIND_PAY, KEY_ONES, 16'hffff, '0, 1'b1, none));
    directed.push_back(row(FN_ATTACH, '0, 16'hffff, '0, 1'b1, none));
    directed.push_back(row(FN_RSVD5, KEY_ONES, 16'hffff, 6'd63, 1'b1, none));
    directed.push_back(row(FN_RSVD6, '0, '0, '0, 1'b1, none));
    directed.push_back(row(FN_RSVD7, KEY_ONES, 16'hffff, 6'd63, 1'b1, none));
    directed.push_back(row(FN_INSERT, KEY_ONES, 16'hffff, 6'd63, 1'b1, none));
    directed.push_back(row(FN_READ_AT, '0, '0, 6'd0, 1'b1,
                           '{hit: 1'b1, rank: 6'd0, key_out: KEY_ONES,
                             payload_out: 16'hffff, overflow: 1'b0}));
    directed.push_back(row(FN_INSERT, '0, '0, '0, 1'b1, none));
    directed.push_back(row(FN_INSERT, 64'h8000_0000_0000_0001, 16'h8001, 6'd1));
    directed.push_back(row(FN_INSERT, 64'h5555_5555_5555_5555, 16'h0000, 6'd2));
    // attach to an empty payload, then again to a filled one
    directed.push_back(row(FN_ATTACH, 64'h5555_5555_5555_5555, 16'h1234, '0));
    directed.push_back(row(FN_ATTACH, 64'h5555_5555_5555_5555, 16'h4321, '0));
    directed.push_back(row(FN_ATTACH, '0, 16'h0007, '0));
    directed.push_back(row(FN_FIND_POS, KEY_ONES, '0, '0));
    // reinsert the back entry: it moves to the front with a new payload
    directed.push_back(row(FN_INSERT, KEY_ONES, 16'h00ff, 6'd5));
    directed.push_back(row(FN_FIND_PAY, KEY_ONES, '0, '0));
    directed.push_back(row(FN_READ_AT, '0, '0, 6'd63, 1'b1, none));
    directed.push_back(row(FN_READ_AT, '0, '0, 6'd3));
    directed.push_back(row(FN_READ_AT, '0, '0, 6'd4, 1'b1, none));
    directed.push_back(row(FN_FIND_POS, 64'haaaa_aaaa_aaaa_aaaa, '0, '0, 1'b1, none));
    directed.push_back(row(FN_INSERT, 64'h8000_0000_0000_0001, 16'h7ffe, 6'd42));
    directed.push_back(row(FN_FIND_PAY, '0, '0, 6'd21));

    // Hold reset, then release it at an edge.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      issue(directed[i]);
      hold_off($urandom_range(0, 3));
    end

    // Let the pipeline run dry once before the random stream.
    drain();

    taken   = 0;
    no_gaps = 1'b0;
    while (taken < RAND_ITEMS) begin
      // Switch now and then to stretches of back-to-back requests.
      if (taken % 50 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      s = random_request();
      issue(s);
      if (s.fn <= FN_FIND_PAY) taken++;
      if ($urandom_range(0, 39) == 0) drain();
      else hold_off(no_gaps ? 0 : $urandom_range(0, MAX_GAP));
    end

    // Wait out the last results and give stray strobes a chance to show.
    drain();
    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatches == 0) begin
      $display("** move_to_front_dictionary: PASSED **");
    end else begin
      $display("** move_to_front_dictionary: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("** move_to_front_dictionary: FAILED **");
    $finish;
  end

endmodule
